### rtl/spdma_pkg.sv
// Shared types and constants for the sprite DMA and pixel select block.
package spdma_pkg;

    // Function codes carried in the func field of an input beat.
    localparam logic [1:0] FUNC_SLOT  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_PTR   = 2'd2;

    // First DMA slot; each later sprite follows four counts on.
    localparam logic [7:0] SLOT_BASE = 8'h14;

    // Width of the byte address that leaves the block.
    localparam int unsigned ADDR_OUT_W = 19;

    // Base colour numbers of a sprite pair.
    localparam logic [5:0] COLOUR_BASE = 6'd32;

    // Configuration register word indexes.
    localparam logic REG_DMA_ENABLE = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  slot_hclock;
        logic [8:0]  line_vpos;
        logic [2:0]  sprite_sel;
        logic [8:0]  pixel_hpos;
        logic [15:0] mem_word_lo;
        logic [15:0] mem_word_hi;
        logic [18:0] pointer_value;
    } in_beat_t;

    typedef struct packed {
        logic        fetched;
        logic [18:0] fetch_addr;
        logic [5:0]  colour_num;
    } out_beat_t;

    // Operation decided by the front end.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_SLOT,
        OP_QUERY,
        OP_PTR
    } op_t;

    // Decoded command that travels through the queue.
    typedef struct packed {
        op_t         op;
        logic [2:0]  idx;
        logic [8:0]  vpos;
        logic [8:0]  hpos;
        logic [15:0] wlo;
        logic [15:0] whi;
        logic [18:0] pval;
    } cmd_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

### rtl/spdma_front.sv
// Front end: configuration register and decode of incoming beats into commands.
module spdma_front #(
    parameter int NUM_SPRITES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    input  spdma_pkg::in_beat_t item,
    output spdma_pkg::cmd_t     cmd
);

    logic       dma_en_reg;
    logic       dma_en_next;
    logic [7:0] slot_diff;
    logic       slot_hit;
    logic       sel_ok;

    // Word index of the register lives in paddr[2].
    always_comb
    begin
        dma_en_next = dma_en_reg;
        if (psel && penable && pwrite && (paddr[2] == spdma_pkg::REG_DMA_ENABLE))
        begin
            dma_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dma_en_reg <= 1'b0;
        end
        else
        begin
            dma_en_reg <= dma_en_next;
        end
    end

    assign prdata = (paddr[2] == spdma_pkg::REG_DMA_ENABLE) ? {31'b0, dma_en_reg} : 32'b0;

    // A slot belongs to sprite n when the count is SLOT_BASE plus four times n.
    assign slot_diff = item.slot_hclock - spdma_pkg::SLOT_BASE;
    assign slot_hit  = dma_en_reg && (item.slot_hclock >= spdma_pkg::SLOT_BASE) &&
                       (slot_diff[1:0] == 2'b00) &&
                       (slot_diff[7:2] < 6'(NUM_SPRITES));
    assign sel_ok    = {1'b0, item.sprite_sel} < 4'(NUM_SPRITES);

    always_comb
    begin
        cmd.op   = spdma_pkg::OP_NONE;
        cmd.idx  = item.sprite_sel;
        cmd.vpos = item.line_vpos;
        cmd.hpos = item.pixel_hpos;
        cmd.wlo  = item.mem_word_lo;
        cmd.whi  = item.mem_word_hi;
        cmd.pval = item.pointer_value;
        unique case (item.func)
            spdma_pkg::FUNC_SLOT:
            begin
                cmd.idx = slot_diff[4:2];
                if (slot_hit)
                begin
                    cmd.op = spdma_pkg::OP_SLOT;
                end
            end
            spdma_pkg::FUNC_QUERY:
            begin
                if (sel_ok)
                begin
                    cmd.op = spdma_pkg::OP_QUERY;
                end
            end
            spdma_pkg::FUNC_PTR:
            begin
                if (sel_ok)
                begin
                    cmd.op = spdma_pkg::OP_PTR;
                end
            end
            default:
            begin
                cmd.op = spdma_pkg::OP_NONE;
            end
        endcase
    end

endmodule

### rtl/spdma_fifo.sv
// Two-entry command queue between the front and back ends.
module spdma_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  spdma_pkg::cmd_t      push_cmd,
    input  logic                 pop,
    output spdma_pkg::cmd_t      head_cmd,
    output spdma_pkg::q_stat_t   stat
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    spdma_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd       = mem_reg[rd_ptr_reg];
    assign stat.full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign stat.not_empty = (count_reg != '0);

endmodule

### rtl/spdma_back.sv
// Back end: per-sprite state, DMA slot execution, pixel colour and result register.
module spdma_back #(
    parameter int NUM_SPRITES = 8,
    parameter int ADDR_BITS   = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spdma_pkg::cmd_t      cmd,
    input  spdma_pkg::q_stat_t   stat,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output spdma_pkg::out_beat_t result
);

    localparam int IDX_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
    localparam int OW    = spdma_pkg::ADDR_OUT_W;

    logic                 active_reg [NUM_SPRITES];
    logic [ADDR_BITS-2:0] ptr_reg    [NUM_SPRITES];
    logic [15:0]          pos_reg    [NUM_SPRITES];
    logic [15:0]          ctl_reg    [NUM_SPRITES];
    logic [15:0]          data_a_reg [NUM_SPRITES];
    logic [15:0]          data_b_reg [NUM_SPRITES];

    logic                 result_valid_reg;
    logic                 result_valid_next;
    spdma_pkg::out_beat_t result_reg;
    spdma_pkg::out_beat_t result_next;

    logic [IDX_W-1:0]     n;
    logic                 cur_active;
    logic [ADDR_BITS-2:0] cur_ptr;
    logic [15:0]          cur_pos;
    logic [15:0]          cur_ctl;
    logic [15:0]          cur_a;
    logic [15:0]          cur_b;
    logic [8:0]           vstart;
    logic [8:0]           vstop;
    logic [8:0]           hstart;
    logic [8:0]           hdiff;
    logic [3:0]           bit_sel;
    logic                 px_a;
    logic                 px_b;
    logic                 act_eff;
    logic                 in_win;
    logic                 past_stop;
    logic                 both_nz;
    logic [ADDR_BITS+OW-1:0] pval_ext;
    logic [ADDR_BITS+OW-1:0] addr_ext;

    logic                 wr_slot;
    logic                 wr_posctl;
    logic                 wr_data;
    logic                 wr_ptr;
    logic                 new_active;
    logic [ADDR_BITS-2:0] new_ptr;

    assign pop = stat.not_empty && (!result_valid_reg || !result_stall);

    assign n          = cmd.idx[IDX_W-1:0];
    assign cur_active = active_reg[n];
    assign cur_ptr    = ptr_reg[n];
    assign cur_pos    = pos_reg[n];
    assign cur_ctl    = ctl_reg[n];
    assign cur_a      = data_a_reg[n];
    assign cur_b      = data_b_reg[n];

    assign vstart = {cur_ctl[2], cur_pos[15:8]};
    assign vstop  = {cur_ctl[1], cur_ctl[15:8]};
    assign hstart = {cur_pos[7:0], cur_ctl[0]};

    // Line zero clears the active flag before the slot acts.
    assign act_eff   = cur_active && (cmd.vpos != 9'd0);
    assign in_win    = (cmd.vpos >= vstart);
    assign past_stop = (cmd.vpos > vstop);
    assign both_nz   = (cmd.wlo != 16'd0) && (cmd.whi != 16'd0);

    // Pixel bit: data bit 15 minus the offset from the left edge.
    assign hdiff   = cmd.hpos - hstart;
    assign bit_sel = ~hdiff[3:0];
    assign px_a    = cur_a[bit_sel];
    assign px_b    = cur_b[bit_sel];

    assign pval_ext = {{ADDR_BITS{1'b0}}, cmd.pval};
    assign addr_ext = {{OW{1'b0}}, cur_ptr, 1'b0};

    always_comb
    begin
        wr_slot    = pop && (cmd.op == spdma_pkg::OP_SLOT);
        wr_posctl  = wr_slot && !act_eff;
        wr_data    = wr_slot && act_eff && in_win && !past_stop;
        wr_ptr     = wr_slot || (pop && (cmd.op == spdma_pkg::OP_PTR));
        new_active = act_eff ? !(in_win && past_stop) : both_nz;
        new_ptr    = cur_ptr;
        if (cmd.op == spdma_pkg::OP_PTR)
        begin
            new_ptr = pval_ext[ADDR_BITS-1:1];
        end
        else if (wr_data || (!act_eff && both_nz))
        begin
            new_ptr = cur_ptr + (ADDR_BITS-1)'(2);
        end
    end

    always_comb
    begin
        result_next = '0;
        unique case (cmd.op)
            spdma_pkg::OP_SLOT:
            begin
                if (!act_eff || (in_win && !past_stop))
                begin
                    result_next.fetched    = 1'b1;
                    result_next.fetch_addr = addr_ext[OW-1:0];
                end
            end
            spdma_pkg::OP_QUERY:
            begin
                if (in_win && !past_stop && (cmd.hpos >= hstart) &&
                    (hdiff[8:4] == 5'd0) && (px_a || px_b))
                begin
                    result_next.colour_num = spdma_pkg::COLOUR_BASE +
                                             {3'b0, px_b, px_a, 1'b0} +
                                             {2'b0, cmd.idx[2:1], 2'b0};
                end
            end
            spdma_pkg::OP_PTR,
            spdma_pkg::OP_NONE:
            begin
                result_next = '0;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pop)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SPRITES; i++)
            begin
                active_reg[i] <= 1'b0;
                ptr_reg[i]    <= '0;
                pos_reg[i]    <= '0;
                ctl_reg[i]    <= '0;
                data_a_reg[i] <= '0;
                data_b_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_slot)
            begin
                active_reg[n] <= new_active;
            end
            if (wr_ptr)
            begin
                ptr_reg[n] <= new_ptr;
            end
            if (wr_posctl)
            begin
                pos_reg[n] <= cmd.wlo;
                ctl_reg[n] <= cmd.whi;
            end
            if (wr_data)
            begin
                data_a_reg[n] <= cmd.wlo;
                data_b_reg[n] <= cmd.whi;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/sprite_dma_and_pixel_select_top.sv
// Top level of the sprite DMA and pixel select block.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    spdma_pkg::in_beat_t
//   result    out        result_valid / result_stall spdma_pkg::out_beat_t
//   config    in         APB (psel, penable, ...)   sprite_dma_enable at word 0
//
// One item beat is taken per cycle while the queue is not full and one result
// beat leaves per cycle while result_stall is low; the rate is set by the back end,
// which reads and updates one sprite entry per cycle when the result is not stalled.
// An item beat passes through the command queue and then the result register,
// from which its result beat leaves.
// Reset clears the DMA enable, every sprite entry and both handshakes at once.
// A stalled result holds in the result register while the two-entry queue still
// takes item beats; item_stall rises only when that queue is full.
module sprite_dma_and_pixel_select_top #(
    parameter int NUM_SPRITES = 8,
    parameter int ADDR_BITS   = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  spdma_pkg::in_beat_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output spdma_pkg::out_beat_t result
);

    spdma_pkg::cmd_t    front_cmd;
    spdma_pkg::cmd_t    head_cmd;
    spdma_pkg::q_stat_t q_stat;
    logic               push;
    logic               pop;

    assign pready = 1'b1;

    // The front end decodes the beat against the enable register.
    spdma_front #(
        .NUM_SPRITES (NUM_SPRITES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .item    (item),
        .cmd     (front_cmd)
    );

    // A beat is taken whenever the queue has room.
    assign item_stall = q_stat.full;
    assign push       = item_valid && !q_stat.full;

    spdma_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // The back end owns all sprite state and the result register.
    spdma_back #(
        .NUM_SPRITES (NUM_SPRITES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .stat         (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
